/* design/nrtb_pkg.sv */
// Package for the neighbor RSSI table: field widths, operation codes,
// controller states and the per-slot cell record. No dependencies.
`default_nettype none

package nrtb_pkg;

  localparam int ADDR_W = 16;
  localparam int RSSI_W = 8;
  localparam int LQI_W  = 8;
  localparam int IDX_W  = 4;

  localparam logic OP_BEACON = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic signed [RSSI_W-1:0] RSSI_MAX = 8'sd127;
  localparam logic signed [RSSI_W-1:0] RSSI_MIN = -8'sd128;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0]        addr;
    logic signed [RSSI_W-1:0] rssi;
    logic [LQI_W-1:0]         lqi;
  } cell_t;

endpackage

`default_nettype wire

/* design/nrtb_cell.sv */
// One neighbor table slot: holds an address, RSSI and link quality and
// takes its neighbor's record whenever the ring shifts. Uses nrtb_pkg.
`default_nettype none

module nrtb_cell (
  input  wire logic           clk_i,
  input  wire logic           shift_i,
  input  wire nrtb_pkg::cell_t d_i,
  output nrtb_pkg::cell_t      q_o
);
  import nrtb_pkg::*;

  cell_t rec_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      rec_q <= d_i;
    end
  end

  assign q_o = rec_q;

endmodule

`default_nettype wire

/* design/neighbor_rssi_table_best_select.sv */
// An item is taken in the idle state, then the slot ring rotates once through
// all slots; the result is registered at the end of the rotation.
// One item is scanned at a time, set by the single head slot that every entry
// passes in turn. The next item is taken while a result waits.
// Reset: entry count and offset clear to zero; slot contents are not reset.
// Depends on nrtb_pkg and nrtb_cell.
`default_nettype none

module neighbor_rssi_table_best_select #(
  parameter int ENTRIES = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  output      logic                                 cfg_ready_o,
  input  wire logic signed [nrtb_pkg::RSSI_W-1:0]   cfg_data_i,
  input  wire logic                                 in_valid_i,
  output      logic                                 in_ready_o,
  input  wire logic                                 operation_i,
  input  wire logic [nrtb_pkg::ADDR_W-1:0]          sender_address_i,
  input  wire logic signed [nrtb_pkg::RSSI_W-1:0]   rssi_raw_i,
  input  wire logic [nrtb_pkg::LQI_W-1:0]           link_quality_i,
  output      logic                                 out_valid_o,
  input  wire logic                                 out_ready_i,
  output      logic [nrtb_pkg::IDX_W-1:0]           entry_index_o,
  output      logic                                 was_new_o,
  output      logic                                 table_full_o,
  output      logic                                 best_found_o,
  output      logic [nrtb_pkg::ADDR_W-1:0]          best_address_o,
  output      logic signed [nrtb_pkg::RSSI_W-1:0]   best_rssi_o
);
  import nrtb_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] LAST_STEP = CW'(ENTRIES - 1);

  state_e state_q, state_d;

  logic signed [RSSI_W-1:0] offset_q;
  logic [CW-1:0]            count_q, count_d;
  logic [CW-1:0]            step_q, step_d;

  // item being worked on
  logic                     op_q, op_d;
  logic [ADDR_W-1:0]        addr_q, addr_d;
  logic signed [RSSI_W-1:0] rss_q, rss_d;
  logic [LQI_W-1:0]         lqi_q, lqi_d;

  // scan progress
  logic                     hit_q, hit_d;
  logic                     new_q, new_d;
  logic [CW-1:0]            slot_q, slot_d;
  logic                     found_q, found_d;
  logic signed [RSSI_W-1:0] best_q, best_d;
  logic [ADDR_W-1:0]        best_addr_q, best_addr_d;

  // result register
  logic                     ovalid_q, ovalid_d;
  logic [IDX_W-1:0]         oidx_q, oidx_d;
  logic                     onew_q, onew_d;
  logic                     ofull_q, ofull_d;
  logic                     ofound_q, ofound_d;
  logic [ADDR_W-1:0]        oaddr_q, oaddr_d;
  logic signed [RSSI_W-1:0] orssi_q, orssi_d;

  cell_t cell_q [ENTRIES];
  cell_t head, head_mod;
  logic  shift;

  logic signed [RSSI_W:0] sum;
  logic                   in_tab, match, append, take, last, out_free;

  assign sum = {rssi_raw_i[RSSI_W-1], rssi_raw_i} + {offset_q[RSSI_W-1], offset_q};

  assign head = cell_q[0];

  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      cell_t d;
      if (gi == ENTRIES - 1) begin : g_tail
        assign d = head_mod;
      end else begin : g_mid
        assign d = cell_q[gi+1];
      end
      nrtb_cell u_cell (
        .clk_i  (clk_i),
        .shift_i(shift),
        .d_i    (d),
        .q_o    (cell_q[gi])
      );
    end
  endgenerate

  assign in_tab   = step_q < count_q;
  assign last     = step_q == LAST_STEP;
  assign out_free = !ovalid_q || out_ready_i;
  assign match    = (op_q == OP_BEACON) && in_tab && !hit_q && (head.addr == addr_q);
  assign append   = (op_q == OP_BEACON) && (step_q == count_q) && !hit_q;
  assign take     = (op_q == OP_TICK) && in_tab && (!found_q || head.rssi >= best_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    step_d      = step_q;
    op_d        = op_q;
    addr_d      = addr_q;
    rss_d       = rss_q;
    lqi_d       = lqi_q;
    hit_d       = hit_q;
    new_d       = new_q;
    slot_d      = slot_q;
    found_d     = found_q;
    best_d      = best_q;
    best_addr_d = best_addr_q;
    ovalid_d    = ovalid_q && !out_ready_i;
    oidx_d      = oidx_q;
    onew_d      = onew_q;
    ofull_d     = ofull_q;
    ofound_d    = ofound_q;
    oaddr_d     = oaddr_q;
    orssi_d     = orssi_q;
    head_mod    = head;
    shift       = 1'b0;
    in_ready_o  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d        = operation_i;
          addr_d      = sender_address_i;
          lqi_d       = link_quality_i;
          if (sum > (RSSI_W+1)'(RSSI_MAX)) begin
            rss_d = RSSI_MAX;
          end else if (sum < (RSSI_W+1)'(RSSI_MIN)) begin
            rss_d = RSSI_MIN;
          end else begin
            rss_d = sum[RSSI_W-1:0];
          end
          step_d      = '0;
          hit_d       = 1'b0;
          new_d       = 1'b0;
          slot_d      = '0;
          found_d     = 1'b0;
          best_d      = '0;
          best_addr_d = '0;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // the last step waits until the result register is free
        if (!last || out_free) begin
          shift = 1'b1;
          if (match) begin
            head_mod.rssi = rss_q;
            head_mod.lqi  = lqi_q;
            hit_d         = 1'b1;
            slot_d        = step_q;
          end
          if (append) begin
            head_mod.addr = addr_q;
            head_mod.rssi = rss_q;
            head_mod.lqi  = lqi_q;
            hit_d         = 1'b1;
            new_d         = 1'b1;
            slot_d        = step_q;
            count_d       = count_q + CW'(1);
          end
          if (take) begin
            found_d     = 1'b1;
            best_d      = head.rssi;
            best_addr_d = head.addr;
          end
          step_d = step_q + CW'(1);
          if (last) begin
            ovalid_d = 1'b1;
            state_d  = ST_IDLE;
            if (op_q == OP_BEACON) begin
              oidx_d   = hit_d ? IDX_W'(slot_d) : '0;
              onew_d   = new_d;
              ofull_d  = !hit_d;
              ofound_d = 1'b0;
              oaddr_d  = '0;
              orssi_d  = '0;
            end else begin
              oidx_d   = '0;
              onew_d   = 1'b0;
              ofull_d  = 1'b0;
              ofound_d = found_d;
              oaddr_d  = best_addr_d;
              orssi_d  = best_d;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      offset_q <= '0;
      count_q  <= '0;
      step_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      step_q   <= step_d;
      ovalid_q <= ovalid_d;
      if (cfg_valid_i) begin
        offset_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    addr_q      <= addr_d;
    rss_q       <= rss_d;
    lqi_q       <= lqi_d;
    hit_q       <= hit_d;
    new_q       <= new_d;
    slot_q      <= slot_d;
    found_q     <= found_d;
    best_q      <= best_d;
    best_addr_q <= best_addr_d;
    oidx_q      <= oidx_d;
    onew_q      <= onew_d;
    ofull_q     <= ofull_d;
    ofound_q    <= ofound_d;
    oaddr_q     <= oaddr_d;
    orssi_q     <= orssi_d;
  end

  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = ovalid_q;
  assign entry_index_o  = oidx_q;
  assign was_new_o      = onew_q;
  assign table_full_o   = ofull_q;
  assign best_found_o   = ofound_q;
  assign best_address_o = oaddr_q;
  assign best_rssi_o    = orssi_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(ENTRIES))
    else $error("entry count beyond table size");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> count_q == $past(count_q) + CW'(1))
    else $error("entry count moved by more than one");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q < CW'(ENTRIES) || state_q == ST_IDLE)
    else $error("scan step past last slot");

  a_new_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(was_new_o && table_full_o))
    else $error("beacon result both new and full");

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == ST_SCAN)
    else $error("accepted item did not start a scan");
`endif

endmodule

`default_nettype wire

/* verif/neighbor_rssi_table_best_select_test.sv */
// Self-checking testbench for neighbor_rssi_table_best_select: directed table
// cases, then randomized beacon/tick traffic under several handshake pacings.
// Depends on nrtb_pkg and the RTL of the block.
`timescale 1ns / 100ps

module neighbor_rssi_table_best_select_test;
  import nrtb_pkg::*;

  localparam int ENTRIES       = 16;
  localparam int SETTLE_CYCLES = ENTRIES + 8;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int PHASE_ITEMS   = 375;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic                     was_new;
    logic                     full;
    logic                     found;
    logic [ADDR_W-1:0]        addr;
    logic signed [RSSI_W-1:0] rssi;
  } nb_result_t;

  bit clk_i = 1'b0;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic signed [RSSI_W-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  logic operation_i;
  logic [ADDR_W-1:0] sender_address_i;
  logic signed [RSSI_W-1:0] rssi_raw_i;
  logic [LQI_W-1:0] link_quality_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [IDX_W-1:0] entry_index_o;
  logic was_new_o;
  logic table_full_o;
  logic best_found_o;
  logic [ADDR_W-1:0] best_address_o;
  logic signed [RSSI_W-1:0] best_rssi_o;

  // predictor state
  logic signed [RSSI_W-1:0] cur_offset = '0;
  int tbl_count = 0;
  logic [ADDR_W-1:0] tbl_addr [ENTRIES];
  logic signed [RSSI_W-1:0] tbl_rssi [ENTRIES];

  nb_result_t pending_results [$];
  nb_result_t want_res;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int errors = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int n_added = 0;
  int n_updated = 0;
  int n_dropped = 0;
  int n_ticks = 0;
  int n_empty_ticks = 0;
  int offsets_written = 0;

  neighbor_rssi_table_best_select #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .sender_address_i(sender_address_i),
    .rssi_raw_i      (rssi_raw_i),
    .link_quality_i  (link_quality_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .entry_index_o   (entry_index_o),
    .was_new_o       (was_new_o),
    .table_full_o    (table_full_o),
    .best_found_o    (best_found_o),
    .best_address_o  (best_address_o),
    .best_rssi_o     (best_rssi_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("** neighbor_rssi_table_best_select: FAILED **");
      $finish;
    end
  end

  function automatic int find_slot(logic [ADDR_W-1:0] addr);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_addr[i] == addr) return i;
    end
    return -1;
  endfunction

  function automatic nb_result_t predict_neighbor_result(logic op, logic [ADDR_W-1:0] addr,
                                                         logic signed [RSSI_W-1:0] raw);
    nb_result_t res;
    int sum;
    int slot;
    int best;
    res = '0;
    best = 0;
    if (op == OP_BEACON) begin
      sum = int'(raw) + int'(cur_offset);
      if (sum > int'(RSSI_MAX)) sum = int'(RSSI_MAX);
      if (sum < int'(RSSI_MIN)) sum = int'(RSSI_MIN);
      slot = find_slot(addr);
      if (slot >= 0) begin
        tbl_rssi[slot] = sum[RSSI_W-1:0];
        res.idx = slot[IDX_W-1:0];
        n_updated++;
      end else if (tbl_count < ENTRIES) begin
        slot = tbl_count;
        tbl_addr[slot] = addr;
        tbl_rssi[slot] = sum[RSSI_W-1:0];
        tbl_count++;
        res.idx = slot[IDX_W-1:0];
        res.was_new = 1'b1;
        n_added++;
      end else begin
        res.full = 1'b1;
        n_dropped++;
      end
    end else begin
      // ">=" lets a later entry take a tie
      for (int i = 0; i < tbl_count; i++) begin
        if (!res.found || tbl_rssi[i] >= best) begin
          best = tbl_rssi[i];
          res.addr = tbl_addr[i];
          res.found = 1'b1;
        end
      end
      if (res.found) res.rssi = best[RSSI_W-1:0];
      else n_empty_ticks++;
      n_ticks++;
    end
    return res;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no item outstanding: expected none, got idx %h addr %h",
                 $time, entry_index_o, best_address_o);
        errors++;
      end else begin
        want_res = pending_results.pop_front();
        check_field("entry_index", want_res.idx, entry_index_o);
        check_field("was_new", want_res.was_new, was_new_o);
        check_field("table_full", want_res.full, table_full_o);
        check_field("best_found", want_res.found, best_found_o);
        check_field("best_address", want_res.addr, best_address_o);
        check_field("best_rssi", want_res.rssi, best_rssi_o);
        results_checked++;
      end
    end
    out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
  end

  task automatic send_item(logic op, logic [ADDR_W-1:0] addr, logic signed [RSSI_W-1:0] raw,
                           logic [LQI_W-1:0] lqi);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    sender_address_i <= addr;
    rssi_raw_i <= raw;
    link_quality_i <= lqi;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_neighbor_result(op, addr, raw));
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_offset(logic signed [RSSI_W-1:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_offset = value;
    offsets_written++;
  endtask

  function automatic logic [ADDR_W-1:0] fresh_address();
    logic [ADDR_W-1:0] addr;
    addr = ADDR_W'($urandom_range(16'hFFFF));
    while (find_slot(addr) >= 0) addr = ADDR_W'($urandom_range(16'hFFFF));
    return addr;
  endfunction

  task automatic test_empty_table_tick();
    send_item(OP_TICK, 16'hFFFF, 8'sh7F, 8'hFF);
  endtask

  task automatic test_insert_and_tie();
    send_item(OP_BEACON, 16'h0000, RSSI_MIN, 8'h00);
    send_item(OP_BEACON, 16'hFFFF, RSSI_MAX, 8'hFF);
    send_item(OP_TICK, 16'h0000, 8'sh00, 8'h00);
    // slot 0 rises to equal slot 1; slot 1 must still win
    send_item(OP_BEACON, 16'h0000, RSSI_MAX, 8'hA5);
    send_item(OP_TICK, 16'h0000, 8'sh00, 8'h00);
  endtask

  task automatic test_rssi_saturation();
    write_offset(RSSI_MAX);
    send_item(OP_BEACON, 16'hFFFF, RSSI_MAX, 8'h5A);
    write_offset(RSSI_MIN);
    send_item(OP_BEACON, 16'h0000, RSSI_MIN, 8'h3C);
    send_item(OP_TICK, 16'h0000, 8'sh00, 8'h00);
    write_offset(8'sh00);
  endtask

  task automatic test_fill_until_full();
    while (tbl_count < ENTRIES)
      send_item(OP_BEACON, fresh_address(), RSSI_W'($urandom_range(255)),
                LQI_W'($urandom_range(255)));
    send_item(OP_BEACON, fresh_address(), RSSI_W'($urandom_range(255)),
              LQI_W'($urandom_range(255)));
    send_item(OP_TICK, 16'h0000, 8'sh00, 8'h00);
  endtask

  task automatic run_traffic(int tx_pct, int rx_pct, logic signed [RSSI_W-1:0] offset);
    int pick;
    logic [ADDR_W-1:0] addr;
    logic signed [RSSI_W-1:0] raw;
    write_offset(offset);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      if ($urandom_range(199) == 0) drain_results();
      pick = $urandom_range(99);
      // narrow RSSI spread makes ties common
      if ($urandom_range(2) == 0) raw = RSSI_W'(int'($urandom_range(3)) - 2);
      else raw = RSSI_W'($urandom_range(255));
      if (pick < 20) addr = ADDR_W'($urandom_range(16'hFFFF));
      else if (pick < 85) addr = tbl_addr[$urandom_range(tbl_count - 1)];
      else addr = ADDR_W'($urandom_range(16'hFFFF));
      send_item(pick < 20 ? OP_TICK : OP_BEACON, addr, raw, LQI_W'($urandom_range(255)));
    end
  endtask

  task automatic test_random_traffic();
    run_traffic(0, 0, 8'sh00);
    run_traffic(57, 0, RSSI_MAX);
    run_traffic(0, 57, RSSI_MIN);
    run_traffic(7, 7, RSSI_W'($urandom_range(255)));
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    operation_i <= OP_BEACON;
    sender_address_i <= '0;
    rssi_raw_i <= '0;
    link_quality_i <= '0;
    out_ready_i <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table_tick();
    test_insert_and_tie();
    test_rssi_saturation();
    test_fill_until_full();
    test_random_traffic();

    drain_results();
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived: expected 0 outstanding, got %0d",
               $time, pending_results.size(), pending_results.size());
      errors++;
    end
    $display("Sent %0d items: %0d added, %0d updated, %0d dropped on a full table, %0d ticks",
             items_sent, n_added, n_updated, n_dropped, n_ticks);
    $display("(%0d on an empty table); %0d results checked over %0d offset writes, %0d errors.",
             n_empty_ticks, results_checked, offsets_written, errors);
    if (errors == 0) begin
      $display("** neighbor_rssi_table_best_select: PASSED **");
    end else begin
      $display("** neighbor_rssi_table_best_select: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
design/nrtb_pkg.sv
design/nrtb_cell.sv
design/neighbor_rssi_table_best_select.sv
verif/neighbor_rssi_table_best_select_test.sv
